### rtl/rrca_pkg.sv
package rrca_pkg;

  localparam int WINDOW_DEPTH = 8;
  localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int MAX_RESULTS  = 10;
  localparam int CNT_W        = $clog2(MAX_RESULTS + 1);
  localparam int SEQ_W        = 32;
  localparam int LEN_W        = 12;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
  } item_t;

  typedef struct packed {
    logic             kind;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic [SEQ_W-1:0] ack;
    logic             done;
    logic             last;
  } result_t;

  // Sequence number plus length, held at the largest value instead of wrapping.
  function automatic logic [SEQ_W-1:0] sat_add(input logic [SEQ_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    logic [SEQ_W:0] s;
    s = {1'b0, a} + {{(SEQ_W+1-LEN_W){1'b0}}, b};
    return s[SEQ_W] ? {SEQ_W{1'b1}} : s[SEQ_W-1:0];
  endfunction

endpackage

### rtl/rrca_front.sv
module rrca_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rrca_pkg::item_t      in_item,
  output logic                 q_valid,
  output rrca_pkg::item_t      q_item,
  input  logic                 q_pop
);

  rrca_pkg::item_t mem_r [rrca_pkg::QUEUE_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       pop;

  assign in_ready = (count_r != 2'(rrca_pkg::QUEUE_DEPTH));
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

### rtl/rrca_engine.sv
module rrca_engine (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  rrca_pkg::item_t                 q_item,
  output logic                            q_pop,
  input  logic                            cfg_we,
  input  logic [rrca_pkg::SEQ_W-1:0]      cfg_data,
  output logic                            res_valid,
  input  logic                            res_ready,
  output rrca_pkg::result_t               res
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_ACK   = 2'd2;

  localparam logic [rrca_pkg::IDX_W-1:0] LAST_IDX =
    rrca_pkg::IDX_W'(rrca_pkg::WINDOW_DEPTH - 1);

  logic [1:0]                    state_r, state_nxt;
  logic [rrca_pkg::SEQ_W-1:0]    expected_r, expected_nxt;
  logic                          finished_r, finished_nxt;
  logic [rrca_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic [rrca_pkg::CNT_W-1:0]    n_r, n_nxt;
  logic                          prog_r, prog_nxt;
  logic                          slot_valid_r [rrca_pkg::WINDOW_DEPTH];
  logic [rrca_pkg::SEQ_W-1:0]    slot_seq_r   [rrca_pkg::WINDOW_DEPTH];
  logic [rrca_pkg::LEN_W-1:0]    slot_len_r   [rrca_pkg::WINDOW_DEPTH];
  logic                          out_valid_r;
  rrca_pkg::result_t             out_r;

  logic                          emit_ok;
  logic                          emit;
  rrca_pkg::result_t             emit_res;
  logic                          dup;
  logic                          free_found;
  logic [rrca_pkg::IDX_W-1:0]    free_idx;
  logic                          st_en;
  logic                          clr_en;
  logic                          step;
  logic [rrca_pkg::SEQ_W-1:0]    sum;

  assign res_valid = out_valid_r;
  assign res       = out_r;
  assign emit_ok   = !out_valid_r || res_ready;

  // Duplicate check and lowest free slot, compared across the window at once.
  always_comb begin
    dup        = 1'b0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = rrca_pkg::WINDOW_DEPTH - 1; i >= 0; i--) begin
      if (slot_valid_r[i] && slot_seq_r[i] == q_item.seq) begin
        dup = 1'b1;
      end
      if (!slot_valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = rrca_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    expected_nxt = expected_r;
    finished_nxt = finished_r;
    idx_nxt      = idx_r;
    n_nxt        = n_r;
    prog_nxt     = prog_r;
    q_pop        = 1'b0;
    emit         = 1'b0;
    emit_res     = '{rrca_pkg::KIND_ACK, '0, '0, expected_r, 1'b0, 1'b1};
    st_en        = 1'b0;
    clr_en       = 1'b0;
    step         = 1'b0;
    sum          = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (finished_r) begin
            q_pop = 1'b1;
          end else if (emit_ok) begin
            q_pop = 1'b1;
            emit  = 1'b1;
            sum   = rrca_pkg::sat_add(expected_r, q_item.len);
            if (q_item.seq < expected_r) begin
              emit = 1'b1;
            end else if (q_item.seq > expected_r) begin
              st_en = !dup && free_found;
            end else if (q_item.len == '0) begin
              finished_nxt  = 1'b1;
              emit_res.done = 1'b1;
              emit_res.ack  = q_item.seq;
            end else begin
              expected_nxt = sum;
              emit_res     = '{rrca_pkg::KIND_DELIVER, q_item.seq, q_item.len, sum,
                               1'b0, 1'b0};
              n_nxt        = rrca_pkg::CNT_W'(1);
              idx_nxt      = '0;
              prog_nxt     = 1'b0;
              state_nxt    = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        step = 1'b1;
        sum  = rrca_pkg::sat_add(expected_r, slot_len_r[idx_r]);
        if (slot_valid_r[idx_r] && slot_seq_r[idx_r] < expected_r) begin
          clr_en = 1'b1;
        end else if (slot_valid_r[idx_r] && slot_seq_r[idx_r] == expected_r &&
                     n_r < rrca_pkg::CNT_W'(rrca_pkg::MAX_RESULTS - 1)) begin
          if (slot_len_r[idx_r] == '0) begin
            // An end-of-stream entry stops the drain without a delivery.
            clr_en       = 1'b1;
            finished_nxt = 1'b1;
            state_nxt    = ST_ACK;
            step         = 1'b0;
          end else if (emit_ok) begin
            clr_en       = 1'b1;
            emit         = 1'b1;
            expected_nxt = sum;
            emit_res     = '{rrca_pkg::KIND_DELIVER, slot_seq_r[idx_r], slot_len_r[idx_r],
                             sum, 1'b0, 1'b0};
            n_nxt        = n_r + rrca_pkg::CNT_W'(1);
            prog_nxt     = 1'b1;
          end else begin
            step = 1'b0;
          end
        end
        if (step) begin
          if (idx_r == LAST_IDX) begin
            // Another pass follows only if this one delivered something.
            if (prog_nxt) begin
              idx_nxt  = '0;
              prog_nxt = 1'b0;
            end else begin
              state_nxt = ST_ACK;
            end
          end else begin
            idx_nxt = idx_r + rrca_pkg::IDX_W'(1);
          end
        end
      end
      ST_ACK: begin
        if (emit_ok) begin
          emit          = 1'b1;
          emit_res.done = finished_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      expected_r  <= '0;
      finished_r  <= 1'b0;
      idx_r       <= '0;
      n_r         <= '0;
      prog_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < rrca_pkg::WINDOW_DEPTH; i++) begin
        slot_valid_r[i] <= 1'b0;
      end
    end else begin
      state_r    <= state_nxt;
      expected_r <= expected_nxt;
      finished_r <= finished_nxt;
      idx_r      <= idx_nxt;
      n_r        <= n_nxt;
      prog_r     <= prog_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
      if (st_en) begin
        slot_valid_r[free_idx] <= 1'b1;
      end
      if (clr_en) begin
        slot_valid_r[idx_r] <= 1'b0;
      end
      if (cfg_we) begin
        expected_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= emit_res;
    end
    if (st_en) begin
      slot_seq_r[free_idx] <= q_item.seq;
      slot_len_r[free_idx] <= q_item.len;
    end
  end

endmodule

### rtl/reorder_receiver_cumulative_ack_core.sv
// An out-of-order, late or end-of-stream segment gives its single ack, and an in-order one
// its delivery, through the queue entry and then the output register, stalled by out_ready.
// A segment that is not in order leaves the queue as its ack is loaded; an in-order one is
// followed by drain passes, one window slot per cycle unless an output stall holds, then an ack.
// Reset (synchronous, active low) clears the queue, the window valid bits, the expected byte
// and the end-of-stream flag at once; no clearing pass is needed.
module reorder_receiver_cumulative_ack_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rrca_pkg::SEQ_W-1:0]     in_seg_seq,
  input  logic [rrca_pkg::LEN_W-1:0]     in_seg_len,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_result_kind,
  output logic [rrca_pkg::SEQ_W-1:0]     out_out_seq,
  output logic [rrca_pkg::LEN_W-1:0]     out_out_len,
  output logic [rrca_pkg::SEQ_W-1:0]     out_ack_number,
  output logic                           out_stream_done,
  output logic                           out_is_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rrca_pkg::SEQ_W-1:0]     cfg_initial_expected
);

  rrca_pkg::item_t   in_item;
  rrca_pkg::item_t   q_item;
  rrca_pkg::result_t res;
  logic              q_valid;
  logic              q_pop;

  assign in_item   = '{in_seg_seq, in_seg_len};
  assign cfg_ready = 1'b1;

  rrca_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  rrca_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_initial_expected),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign out_result_kind = res.kind;
  assign out_out_seq     = res.seq;
  assign out_out_len     = res.len;
  assign out_ack_number  = res.ack;
  assign out_stream_done = res.done;
  assign out_is_last     = res.last;

endmodule
